// File: sv/tsl_pkg.sv
// Shared types and constants for the torque safety limiter.
// Holds field widths, register index codes and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps

package tsl_pkg;

    localparam int TORQUE_W    = 16;
    localparam int TMAG_W      = 17;
    localparam int ANGLE_W     = 24;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int THRESH_W    = 15;
    localparam int MAXANG_W    = 23;
    localparam int REC_W       = 16;
    localparam int LINK_W      = 8;
    localparam int SUMCFG_W    = 20;
    localparam int CFG_DATA_W  = 23;
    localparam int CFG_INDEX_W = 3;
    localparam int NUM_W       = 26;
    localparam int PROD_W      = 41;
    localparam int QUOT_W      = 15;
    localparam int DIVS_W      = 24;
    localparam int SCALE_W     = 27;

    localparam logic [CFG_INDEX_W-1:0] CFG_ESTOP_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TORQUE_LIMIT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ANGLE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVERY_MS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINK_LOSS_LIMIT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPIKE_SUM       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CALM_SUM        = 3'd6;

    localparam logic [LINK_W-1:0] LINK_COUNT_MAX = 8'd255;

    typedef struct packed {
        logic load;
        logic ring_step;
        logic ring_add;
        logic mul_en;
        logic div_init;
        logic div_step;
        logic commit;
    } tsl_cmd_t;

    typedef struct packed {
        logic out_free;
    } tsl_sts_t;

endpackage

// File: sv/tsl_ctrl.sv
// Sequencing controller for the torque safety limiter.
// Steps the history sweep, the multiply and the divider, then commits
// the beat. Depends on tsl_pkg.
`timescale 1ns / 1ps

module tsl_ctrl
    import tsl_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output tsl_cmd_t cmd,
    input  tsl_sts_t sts
);

    localparam int DIV_LAST  = QUOT_W + 1;
    localparam int CALC_LAST = (HISTORY_DEPTH - 1 > DIV_LAST) ? HISTORY_DEPTH - 1 : DIV_LAST;
    localparam int CNT_W     = $clog2(CALC_LAST + 1);

    localparam logic [CNT_W-1:0] RING_LAST_C = CNT_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] DIV_INIT_C  = CNT_W'(1);
    localparam logic [CNT_W-1:0] DIV_FIRST_C = CNT_W'(2);
    localparam logic [CNT_W-1:0] DIV_LAST_C  = CNT_W'(DIV_LAST);
    localparam logic [CNT_W-1:0] CALC_LAST_C = CNT_W'(CALC_LAST);

    typedef enum logic [2:0] {
        IDLE_S = 3'b001,
        CALC_S = 3'b010,
        DONE_S = 3'b100
    } ctrl_state_t;

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE_S;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            IDLE_S:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = CALC_S;
                end
            end
            CALC_S:
            begin
                cmd.ring_step = (cnt_reg <= RING_LAST_C);
                cmd.ring_add  = (cnt_reg < RING_LAST_C);
                cmd.mul_en    = (cnt_reg == '0);
                cmd.div_init  = (cnt_reg == DIV_INIT_C);
                cmd.div_step  = (cnt_reg >= DIV_FIRST_C) && (cnt_reg <= DIV_LAST_C);
                if (cnt_reg == CALC_LAST_C)
                begin
                    state_next = DONE_S;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DONE_S:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = IDLE_S;
                end
            end
            default:
            begin
                state_next = IDLE_S;
            end
        endcase
    end

    assign in_stall = (state_reg != IDLE_S);

    a_load_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.mul_en)
        else $error("multiply not issued after capture");

    a_commit_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !in_stall)
        else $error("input not reopened after commit");

    a_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DONE_S && $past(state_reg) == CALC_S) |-> $past(cnt_reg) == CALC_LAST_C)
        else $error("calculation left early");

endmodule

// File: sv/tsl_datapath.sv
// Datapath of the torque safety limiter: settings, torque history,
// difference sum, derating multiply and divider, latch state and output beat.
// Depends on tsl_pkg.
`timescale 1ns / 1ps

module tsl_datapath
    import tsl_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [TORQUE_W-1:0] torque_request,
    input  logic signed [ANGLE_W-1:0]  angle_centideg,
    input  logic                       link_ok,
    input  logic [TIME_W-1:0]          now_ms,
    input  tsl_cmd_t                   cmd,
    output tsl_sts_t                   sts,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [TORQUE_W-1:0] torque_out,
    output logic                       violation,
    output logic                       stop_latched,
    output logic [COUNT_W-1:0]         stop_events
);

    localparam int SUM_W = TORQUE_W + $clog2(HISTORY_DEPTH);
    localparam int CMP_W = (SUM_W > SUMCFG_W) ? SUM_W : SUMCFG_W;

    logic [THRESH_W-1:0] estop_reg;
    logic [THRESH_W-1:0] tlimit_reg;
    logic [MAXANG_W-1:0] max_angle_reg;
    logic [REC_W-1:0]    recovery_reg;
    logic [LINK_W-1:0]   link_limit_reg;
    logic [SUMCFG_W-1:0] spike_reg;
    logic [SUMCFG_W-1:0] calm_reg;

    logic signed [TORQUE_W-1:0] hist_reg [HISTORY_DEPTH];
    logic [SUM_W-1:0]           sum_reg;

    logic signed [TORQUE_W-1:0] t_reg;
    logic [TMAG_W-1:0]          tmag_reg;
    logic [ANGLE_W-1:0]         amag_reg;
    logic                       link_reg;
    logic [TIME_W-1:0]          now_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [QUOT_W-1:0] qn_reg;

    logic              flag_reg;
    logic              timing_reg;
    logic [TIME_W-1:0] start_reg;
    logic [LINK_W-1:0] link_count_reg;
    logic [COUNT_W-1:0] stop_count_reg;

    logic                       out_valid_reg;
    logic signed [TORQUE_W-1:0] torque_out_reg;
    logic                       violation_reg;
    logic                       latched_reg;

    logic [TMAG_W-1:0]          tmag_in;
    logic [ANGLE_W-1:0]         amag_in;
    logic signed [TMAG_W-1:0]   diff;
    logic [TORQUE_W-1:0]        diff_mag;
    logic [NUM_W-1:0]           six_max;
    logic [NUM_W-1:0]           five_amag;
    logic [NUM_W-1:0]           num;
    logic [DIVS_W-1:0]          divisor;
    logic [DIVS_W:0]            shifted;
    logic                       fits;

    logic                       stop_cond;
    logic                       calm;
    logic                       derate;
    logic                       at_limit;
    logic [THRESH_W-1:0]        floor_allow;
    logic [THRESH_W-1:0]        allow;
    logic [TIME_W-1:0]          elapsed;

    logic                       flag_next;
    logic                       timing_next;
    logic [TIME_W-1:0]          start_next;
    logic [LINK_W-1:0]          link_count_next;
    logic [COUNT_W-1:0]         stop_count_next;
    logic                       violation_next;
    logic signed [TORQUE_W-1:0] torque_out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estop_reg      <= THRESH_W'(30000);
            tlimit_reg     <= THRESH_W'(20000);
            max_angle_reg  <= MAXANG_W'(45000);
            recovery_reg   <= REC_W'(100);
            link_limit_reg <= LINK_W'(10);
            spike_reg      <= SUMCFG_W'(18000);
            calm_reg       <= SUMCFG_W'(900);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ESTOP_THRESHOLD: estop_reg      <= cfg_data[THRESH_W-1:0];
                CFG_TORQUE_LIMIT:    tlimit_reg     <= cfg_data[THRESH_W-1:0];
                CFG_MAX_ANGLE:       max_angle_reg  <= cfg_data[MAXANG_W-1:0];
                CFG_RECOVERY_MS:     recovery_reg   <= cfg_data[REC_W-1:0];
                CFG_LINK_LOSS_LIMIT: link_limit_reg <= cfg_data[LINK_W-1:0];
                CFG_SPIKE_SUM:       spike_reg      <= cfg_data[SUMCFG_W-1:0];
                CFG_CALM_SUM:        calm_reg       <= cfg_data[SUMCFG_W-1:0];
                default:             ;
            endcase
        end
    end

    // The history is kept newest first; a sweep rotates it once around so
    // that taps 0 and 1 see every adjacent pair and the order is restored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            hist_reg[0] <= torque_request;
            for (int i = 1; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
        else if (cmd.ring_step)
        begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[HISTORY_DEPTH-1] <= hist_reg[0];
        end
    end

    assign tmag_in  = torque_request[TORQUE_W-1]
                    ? TMAG_W'(-{torque_request[TORQUE_W-1], torque_request})
                    : TMAG_W'({1'b0, torque_request});
    assign amag_in  = angle_centideg[ANGLE_W-1]
                    ? ANGLE_W'(-angle_centideg) : ANGLE_W'(angle_centideg);
    assign diff     = {hist_reg[0][TORQUE_W-1], hist_reg[0]}
                    - {hist_reg[1][TORQUE_W-1], hist_reg[1]};
    assign diff_mag = diff[TMAG_W-1] ? TORQUE_W'(-diff) : diff[TORQUE_W-1:0];

    assign six_max   = NUM_W'({max_angle_reg, 2'b00}) + NUM_W'({max_angle_reg, 1'b0});
    assign five_amag = NUM_W'({amag_reg, 2'b00}) + NUM_W'(amag_reg);
    assign num       = six_max - five_amag;
    assign divisor   = {max_angle_reg, 1'b0};
    assign shifted   = {rem_reg, qn_reg[QUOT_W-1]};
    assign fits      = (shifted >= {1'b0, divisor});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg    <= torque_request;
            tmag_reg <= tmag_in;
            amag_reg <= amag_in;
            link_reg <= link_ok;
            now_reg  <= now_ms;
            sum_reg  <= '0;
        end
        else if (cmd.ring_add)
        begin
            sum_reg <= sum_reg + SUM_W'(diff_mag);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(tlimit_reg) * PROD_W'(num);
        end
        if (cmd.div_init)
        begin
            rem_reg <= prod_reg[QUOT_W+DIVS_W-1:QUOT_W];
            qn_reg  <= prod_reg[QUOT_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? DIVS_W'(shifted - {1'b0, divisor}) : shifted[DIVS_W-1:0];
            qn_reg  <= {qn_reg[QUOT_W-2:0], fits};
        end
    end

    assign stop_cond = (tmag_reg > TMAG_W'(estop_reg))
                    || (CMP_W'(sum_reg) > CMP_W'(spike_reg));
    assign calm      = flag_reg
                    && ((TMAG_W + 3)'(tmag_reg) * (TMAG_W + 3)'(5)
                        < (TMAG_W + 3)'(tlimit_reg))
                    && (CMP_W'(sum_reg) < CMP_W'(calm_reg));
    assign elapsed   = now_reg - start_reg;
    assign derate    = (SCALE_W'(amag_reg) * SCALE_W'(5))
                     > (SCALE_W'(max_angle_reg) * SCALE_W'(4));
    assign at_limit  = (amag_reg >= ANGLE_W'(max_angle_reg));
    assign floor_allow = tlimit_reg >> 1;

    always_comb
    begin
        if (!derate)
        begin
            allow = tlimit_reg;
        end
        else if (at_limit || (qn_reg < floor_allow))
        begin
            allow = floor_allow;
        end
        else
        begin
            allow = qn_reg;
        end
    end

    always_comb
    begin
        flag_next       = flag_reg;
        timing_next     = timing_reg;
        start_next      = start_reg;
        link_count_next = link_count_reg;
        stop_count_next = stop_count_reg;
        violation_next  = 1'b0;
        torque_out_next = t_reg;
        if (stop_cond)
        begin
            if (!flag_reg)
            begin
                flag_next       = 1'b1;
                stop_count_next = stop_count_reg + 1'b1;
            end
            violation_next  = 1'b1;
            torque_out_next = '0;
        end
        else
        begin
            if (calm)
            begin
                if (!timing_reg)
                begin
                    start_next  = now_reg;
                    timing_next = 1'b1;
                end
                else if (elapsed > TIME_W'(recovery_reg))
                begin
                    flag_next   = 1'b0;
                    timing_next = 1'b0;
                end
            end
            if (link_reg)
            begin
                link_count_next = '0;
            end
            else if (link_count_reg != LINK_COUNT_MAX)
            begin
                link_count_next = link_count_reg + 1'b1;
            end
            if (flag_next || (!link_reg && (link_count_next > link_limit_reg)))
            begin
                violation_next  = 1'b1;
                torque_out_next = '0;
            end
            else if (tmag_reg > TMAG_W'(allow))
            begin
                torque_out_next = t_reg[TORQUE_W-1] ? -$signed({1'b0, allow})
                                                    : $signed({1'b0, allow});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg       <= 1'b0;
            timing_reg     <= 1'b0;
            start_reg      <= '0;
            link_count_reg <= '0;
            stop_count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            flag_reg       <= flag_next;
            timing_reg     <= timing_next;
            start_reg      <= start_next;
            link_count_reg <= link_count_next;
            stop_count_reg <= stop_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            torque_out_reg <= torque_out_next;
            violation_reg  <= violation_next;
            latched_reg    <= flag_next;
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign torque_out   = torque_out_reg;
    assign violation    = violation_reg;
    assign stop_latched = latched_reg;
    assign stop_events  = stop_count_reg;

    a_violation_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && violation_reg) |-> (torque_out_reg == '0))
        else $error("violation beat carries nonzero torque");

    a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(stop_count_reg))
        else $error("stop count changed outside commit");

    a_count_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !flag_reg && flag_next)
        |=> (stop_count_reg == COUNT_W'($past(stop_count_reg) + 1'b1)))
        else $error("stop entry not counted");

endmodule

// File: sv/torque_safety_limiter_top.sv
// Top level of the torque safety limiter: controller and datapath.
// Depends on tsl_pkg, tsl_ctrl and tsl_datapath.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_stall     torque_request, angle_centideg, link_ok, now_ms
//   out      output     out_valid / out_stall   torque_out, violation, stop_latched, stop_events
//   cfg      input      cfg_write               cfg_index, cfg_data
//
// A beat runs the history sweep alongside the 15-step divider for the
// derating allowance, and the longer of the two sets how long it takes.
// The next input beat is taken the cycle after the result is loaded.
// Reset restores the register defaults and clears history, latch and counters.
// A stalled output holds its beat; a new beat may be accepted meanwhile.
`timescale 1ns / 1ps

module torque_safety_limiter_top
    import tsl_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [TORQUE_W-1:0] torque_request,
    input  logic signed [ANGLE_W-1:0]  angle_centideg,
    input  logic                       link_ok,
    input  logic [TIME_W-1:0]          now_ms,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [TORQUE_W-1:0] torque_out,
    output logic                       violation,
    output logic                       stop_latched,
    output logic [COUNT_W-1:0]         stop_events
);

    tsl_cmd_t cmd;
    tsl_sts_t sts;

    tsl_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    tsl_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .torque_request (torque_request),
        .angle_centideg (angle_centideg),
        .link_ok        (link_ok),
        .now_ms         (now_ms),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .torque_out     (torque_out),
        .violation      (violation),
        .stop_latched   (stop_latched),
        .stop_events    (stop_events)
    );

endmodule

// File: test/tb_torque_safety_limiter_top.sv
// Self-checking testbench for torque_safety_limiter_top: a directed table, then phases of
// random beats under several register settings, checked against a predictor kept in the bench.
// Depends on tsl_pkg and the torque_safety_limiter_top RTL.
`timescale 1ns / 1ps

module tb_torque_safety_limiter_top;
    import tsl_pkg::*;

    localparam int HIST_DEPTH = 10;
    localparam int NUM_PHASES = 6;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] torque;
        logic                       violation;
        logic                       latched;
        logic [COUNT_W-1:0]         events;
    } limit_out_t;

    typedef struct {
        logic signed [TORQUE_W-1:0] torque;
        logic signed [ANGLE_W-1:0]  angle;
        logic                       link;
        logic [TIME_W-1:0]          now;
        bit                         typed;
        limit_out_t                 result;
    } plan_row_t;

    typedef struct packed {
        logic [THRESH_W-1:0] estop;
        logic [THRESH_W-1:0] tlimit;
        logic [MAXANG_W-1:0] maxang;
        logic [REC_W-1:0]    rec;
        logic [LINK_W-1:0]   link_lim;
        logic [SUMCFG_W-1:0] spike;
        logic [SUMCFG_W-1:0] calm;
    } limiter_cfg_t;

    typedef int reg_vals_t [7];

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       cfg_write      = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index      = CFG_ESTOP_THRESHOLD;
    logic [CFG_DATA_W-1:0]      cfg_data       = '0;
    logic                       in_valid       = 1'b0;
    logic                       in_stall;
    logic signed [TORQUE_W-1:0] torque_request = '0;
    logic signed [ANGLE_W-1:0]  angle_centideg = '0;
    logic                       link_ok        = 1'b1;
    logic [TIME_W-1:0]          now_ms         = '0;
    logic                       out_valid;
    logic                       out_stall      = 1'b0;
    logic signed [TORQUE_W-1:0] torque_out;
    logic                       violation;
    logic                       stop_latched;
    logic [COUNT_W-1:0]         stop_events;

    limiter_cfg_t       cfg_now;
    int                 hist [HIST_DEPTH];
    int                 hist_ptr;
    logic               stop_q;
    logic               rec_run;
    logic [TIME_W-1:0]  rec_start;
    logic [LINK_W-1:0]  loss_cnt;
    logic [COUNT_W-1:0] stop_cnt;

    limit_out_t  pending_outputs [$];
    plan_row_t   stim_plan [$];
    limit_out_t  got_want;
    logic [TIME_W-1:0] now_t;
    bit          idle_en;
    int          stall_left;
    int          errors;
    int          beats_in;
    int          beats_out;
    int          viol_seen;
    int          settings_used;

    torque_safety_limiter_top #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .torque_request(torque_request),
        .angle_centideg(angle_centideg),
        .link_ok       (link_ok),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .torque_out    (torque_out),
        .violation     (violation),
        .stop_latched  (stop_latched),
        .stop_events   (stop_events)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("[torque_safety_limiter_top] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0t] output beat %0d, %s: got %0d, expected %0d",
                 $realtime, beats_out, field, got, want);
        errors++;
    endtask

    function automatic limit_out_t limit_torque_step(
        input logic signed [TORQUE_W-1:0] t,
        input logic signed [ANGLE_W-1:0]  a,
        input logic                       lk,
        input logic [TIME_W-1:0]          now
    );
        int                tq;
        int                av;
        int                tmag;
        int                amag;
        int                sum;
        int                d;
        int                k;
        int                allow;
        int                fl;
        int                res;
        longint            num;
        logic [TIME_W-1:0] waited;
        logic              viol;
        limit_out_t        r;
        tq   = t;
        av   = a;
        tmag = (tq < 0) ? -tq : tq;
        amag = (av < 0) ? -av : av;
        hist[hist_ptr] = tq;
        hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
        sum = 0;
        for (k = 0; k + 1 < HIST_DEPTH; k++)
        begin
            d = hist[(hist_ptr + k + 1) % HIST_DEPTH] - hist[(hist_ptr + k) % HIST_DEPTH];
            sum += (d < 0) ? -d : d;
        end
        viol = 1'b0;
        res  = tq;
        if (tmag > cfg_now.estop || sum > cfg_now.spike)
        begin
            if (!stop_q)
            begin
                stop_q   = 1'b1;
                stop_cnt = stop_cnt + 1'b1;
            end
            viol = 1'b1;
            res  = 0;
        end
        else
        begin
            if (stop_q && 5 * tmag < cfg_now.tlimit && sum < cfg_now.calm)
            begin
                if (!rec_run)
                begin
                    rec_start = now;
                    rec_run   = 1'b1;
                end
                waited = now - rec_start;
                if (waited > cfg_now.rec)
                begin
                    stop_q  = 1'b0;
                    rec_run = 1'b0;
                end
            end
            if (!lk)
            begin
                if (loss_cnt < LINK_COUNT_MAX)
                    loss_cnt = loss_cnt + 1'b1;
            end
            else
            begin
                loss_cnt = '0;
            end
            if (stop_q || (!lk && loss_cnt > cfg_now.link_lim))
            begin
                viol = 1'b1;
                res  = 0;
            end
            else
            begin
                allow = cfg_now.tlimit;
                if (longint'(amag) * 5 > longint'(cfg_now.maxang) * 4)
                begin
                    fl = cfg_now.tlimit / 2;
                    if (amag >= cfg_now.maxang)
                    begin
                        allow = fl;
                    end
                    else
                    begin
                        num   = longint'(cfg_now.maxang) * 6 - longint'(amag) * 5;
                        allow = int'(longint'(cfg_now.tlimit) * num
                                     / (longint'(cfg_now.maxang) * 2));
                        if (allow < fl)
                            allow = fl;
                    end
                end
                if (tmag > allow)
                    res = (tq > 0) ? allow : -allow;
            end
        end
        r.torque    = res[TORQUE_W-1:0];
        r.violation = viol;
        r.latched   = stop_q;
        r.events    = stop_cnt;
        return r;
    endfunction

    task automatic add_row(
        input int t, input int a, input logic lk, input logic [TIME_W-1:0] now,
        input bit typed, input int et, input logic ev, input logic el, input int ee
    );
        plan_row_t row;
        row.torque           = t[TORQUE_W-1:0];
        row.angle            = a[ANGLE_W-1:0];
        row.link             = lk;
        row.now              = now;
        row.typed            = typed;
        row.result.torque    = et[TORQUE_W-1:0];
        row.result.violation = ev;
        row.result.latched   = el;
        row.result.events    = ee[COUNT_W-1:0];
        stim_plan.push_back(row);
    endtask

    task automatic send_beat(
        input logic signed [TORQUE_W-1:0] t,
        input logic signed [ANGLE_W-1:0]  a,
        input logic                       lk,
        input logic [TIME_W-1:0]          now,
        input bit                         typed,
        input limit_out_t                 typed_res
    );
        limit_out_t pred;
        int         gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        torque_request <= t;
        angle_centideg <= a;
        link_ok        <= lk;
        now_ms         <= now;
        do
            @(posedge clk);
        while (in_stall);
        pred = limit_torque_step(t, a, lk, now);
        pending_outputs.push_back(typed ? typed_res : pred);
        beats_in++;
        @(negedge clk);
    endtask

    task automatic send_random_beats(input int count, input int first_loss);
        int         tv;
        int         av;
        int         left;
        int         mode;
        int         level;
        int         loss_left;
        logic       lk;
        limit_out_t none;
        none      = '0;
        left      = 0;
        mode      = 0;
        level     = 0;
        loss_left = first_loss;
        repeat (count)
        begin
            if (left == 0)
            begin
                left  = $urandom_range(3, 15);
                mode  = $urandom_range(0, 4);
                level = int'($urandom_range(0, 2 * cfg_now.tlimit + 2))
                        - int'(cfg_now.tlimit) - 1;
            end
            left--;
            case (mode)
                0: tv = int'($urandom_range(0, 60)) - 30;
                1: tv = level + int'($urandom_range(0, 400)) - 200;
                2: tv = int'($urandom_range(0, 65535)) - 32768;
                3: tv = ($urandom_range(0, 1) ? 1 : -1)
                        * (int'(cfg_now.estop) + int'($urandom_range(0, 6)) - 3);
                default:
                begin
                    tv    = level;
                    level = level + int'($urandom_range(0, 1000)) - 500;
                end
            endcase
            if (tv > 32767)
                tv = 32767;
            if (tv < -32768)
                tv = -32768;
            case ($urandom_range(0, 3))
                0, 1: av = ($urandom_range(0, 1) ? 1 : -1)
                           * int'(longint'(cfg_now.maxang) * $urandom_range(70, 130) / 100);
                2: av = int'($urandom_range(0, 2000)) - 1000;
                default: av = int'($urandom_range(0, 16777215)) - 8388608;
            endcase
            if (av > 8388607)
                av = 8388607;
            if (av < -8388608)
                av = -8388608;
            if (loss_left > 0)
            begin
                lk = 1'b0;
                loss_left--;
            end
            else if ($urandom_range(0, 14) == 0)
            begin
                lk        = 1'b0;
                loss_left = $urandom_range(0, 24);
            end
            else
            begin
                lk = 1'b1;
            end
            if ($urandom_range(0, 49) == 0)
                now_t = $urandom;
            else
                now_t = now_t + $urandom_range(1, 40);
            send_beat(tv[TORQUE_W-1:0], av[ANGLE_W-1:0], lk, now_t, 1'b0, none);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_ESTOP_THRESHOLD: cfg_now.estop    = value[THRESH_W-1:0];
            CFG_TORQUE_LIMIT:    cfg_now.tlimit   = value[THRESH_W-1:0];
            CFG_MAX_ANGLE:       cfg_now.maxang   = value[MAXANG_W-1:0];
            CFG_RECOVERY_MS:     cfg_now.rec      = value[REC_W-1:0];
            CFG_LINK_LOSS_LIMIT: cfg_now.link_lim = value[LINK_W-1:0];
            CFG_SPIKE_SUM:       cfg_now.spike    = value[SUMCFG_W-1:0];
            CFG_CALM_SUM:        cfg_now.calm     = value[SUMCFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input reg_vals_t v);
        write_reg(CFG_ESTOP_THRESHOLD, v[0]);
        write_reg(CFG_TORQUE_LIMIT,    v[1]);
        write_reg(CFG_MAX_ANGLE,       v[2]);
        write_reg(CFG_RECOVERY_MS,     v[3]);
        write_reg(CFG_LINK_LOSS_LIMIT, v[4]);
        write_reg(CFG_SPIKE_SUM,       v[5]);
        write_reg(CFG_CALM_SUM,        v[6]);
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Phase 4 writes values with bits above the register widths to exercise masking.
    function automatic reg_vals_t phase_settings(input int ph);
        reg_vals_t v;
        case (ph)
            1: v = '{8000, 6000, 1000, 5, 2, 6000, 3000};
            2: v = '{32767, 32767, 8388607, 65535, 254, 1048575, 1048575};
            3: v = '{0, 0, 1, 0, 0, 0, 0};
            4: v = '{32'h7F_4E20, 15000, 0, 20, 32'h7F_FFFF, 20000, 2000};
            default:
            begin
                v[0] = $urandom_range(5000, 32767);
                v[1] = $urandom_range(1000, 32767);
                v[2] = $urandom_range(1, 400000);
                v[3] = $urandom_range(0, 300);
                v[4] = $urandom_range(0, 30);
                v[5] = $urandom_range(2000, 60000);
                v[6] = $urandom_range(0, 5000);
            end
        endcase
        return v;
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n || !idle_en)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                report_mismatch("beat with nothing expected, torque_out", torque_out, 0);
            end
            else
            begin
                got_want = pending_outputs.pop_front();
                if (torque_out !== got_want.torque)
                    report_mismatch("torque_out", torque_out, got_want.torque);
                if (violation !== got_want.violation)
                    report_mismatch("violation", violation, got_want.violation);
                if (stop_latched !== got_want.latched)
                    report_mismatch("stop_latched", stop_latched, got_want.latched);
                if (stop_events !== got_want.events)
                    report_mismatch("stop_events", stop_events, got_want.events);
                if (got_want.violation)
                    viol_seen++;
            end
            beats_out++;
        end
    end

    initial
    begin
        int i;
        int ph;
        int cnt;
        int first_loss;
        cfg_now  = '{30000, 20000, 45000, 100, 10, 18000, 900};
        for (i = 0; i < HIST_DEPTH; i++)
            hist[i] = 0;
        hist_ptr      = 0;
        stop_q        = 1'b0;
        rec_run       = 1'b0;
        rec_start     = '0;
        loss_cnt      = '0;
        stop_cnt      = '0;
        idle_en       = 1'b1;
        stall_left    = 0;
        errors        = 0;
        beats_in      = 0;
        beats_out     = 0;
        viol_seen     = 0;
        settings_used = 1;

        add_row(0, 0, 1'b1, 0, 1'b1, 0, 1'b0, 1'b0, 0);
        add_row(32767, 12000, 1'b1, 10, 1'b1, 0, 1'b1, 1'b1, 1);
        add_row(-32768, -12000, 1'b1, 20, 1'b1, 0, 1'b1, 1'b1, 1);
        for (i = 0; i < 9; i++)
            add_row(0, 0, 1'b1, 30 + 10 * i, 1'b0, 0, 1'b0, 1'b0, 0);
        add_row(0, 0, 1'b1, 1000, 1'b0, 0, 1'b0, 1'b0, 0);
        add_row(0, 0, 1'b1, 1050, 1'b0, 0, 1'b0, 1'b0, 0);
        add_row(0, 0, 1'b1, 1101, 1'b1, 0, 1'b0, 1'b0, 1);
        add_row(15000, 45000, 1'b1, 1110, 1'b0, 0, 1'b0, 1'b0, 0);
        add_row(15000, -8388608, 1'b1, 1120, 1'b0, 0, 1'b0, 1'b0, 0);
        add_row(14000, -38000, 1'b1, 1130, 1'b0, 0, 1'b0, 1'b0, 0);
        add_row(14000, 44000, 1'b1, 1140, 1'b0, 0, 1'b0, 1'b0, 0);
        add_row(14000, 8388607, 1'b0, 1150, 1'b0, 0, 1'b0, 1'b0, 0);
        add_row(0, 0, 1'b1, 32'hFFFF_FFFF, 1'b0, 0, 1'b0, 1'b0, 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_plan[j])
            send_beat(stim_plan[j].torque, stim_plan[j].angle, stim_plan[j].link,
                      stim_plan[j].now, stim_plan[j].typed, stim_plan[j].result);

        now_t = 32'hFFFF_FE00;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                in_valid <= 1'b0;
                while (pending_outputs.size() != 0)
                    @(negedge clk);
                repeat (25) @(negedge clk);
                apply_settings(phase_settings(ph));
                @(negedge clk);
            end
            if (ph == NUM_PHASES - 1)
                idle_en = 1'b0;
            // The widest link limit needs a loss longer than the counter can count.
            first_loss = (ph == 2) ? 270 : 0;
            case (ph)
                2: cnt = 290;
                3: cnt = 15;
                default: cnt = 20;
            endcase
            send_random_beats(cnt, first_loss);
        end
        in_valid <= 1'b0;

        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Sent %0d input beats under %0d register settings; %0d results checked.",
                 beats_in, settings_used, beats_out);
        $display("Of those, %0d carried a violation and %0d stops were entered.",
                 viol_seen, stop_cnt);
        if (errors == 0)
            $display("[torque_safety_limiter_top] OK");
        else
            $display("[torque_safety_limiter_top] ERROR");
        $finish;
    end

endmodule
